// ===== src/ttit_pkg.sv =====
`default_nettype none

package ttit_pkg;

  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  function automatic logic sg_nz(input sgn_t a);
    return a.pos | a.neg;
  endfunction

  function automatic logic sg_prod_pos(input sgn_t a, input sgn_t b);
    return (a.pos & b.pos) | (a.neg & b.neg);
  endfunction

  function automatic logic sg_prod_neg(input sgn_t a, input sgn_t b);
    return (a.pos & b.neg) | (a.neg & b.pos);
  endfunction

endpackage

`default_nettype wire

// ===== src/ttit_orient2.sv =====
`default_nettype none

module ttit_orient2 #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         en_prod,
  input  wire logic                         en_sign,
  input  wire logic signed [COORD_BITS-1:0] a_u,
  input  wire logic signed [COORD_BITS-1:0] a_v,
  input  wire logic signed [COORD_BITS-1:0] b_u,
  input  wire logic signed [COORD_BITS-1:0] b_v,
  input  wire logic signed [COORD_BITS-1:0] p_u,
  input  wire logic signed [COORD_BITS-1:0] p_v,
  output ttit_pkg::sgn_t                    sign_r
);
  import ttit_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int MW = 2 * DW;
  localparam int RW = MW + 1;

  logic signed [DW-1:0] du_ab, dv_ab, du_ap, dv_ap;
  logic signed [MW-1:0] m0_r, m1_r;
  logic signed [RW-1:0] diff;

  assign du_ab = DW'(b_u) - DW'(a_u);
  assign dv_ab = DW'(b_v) - DW'(a_v);
  assign du_ap = DW'(p_u) - DW'(a_u);
  assign dv_ap = DW'(p_v) - DW'(a_v);
  assign diff  = RW'(m0_r) - RW'(m1_r);

  always_ff @(posedge clk) begin
    if (en_prod) begin
      m0_r <= MW'(du_ab) * MW'(dv_ap);
      m1_r <= MW'(dv_ab) * MW'(du_ap);
    end
    if (en_sign) begin
      sign_r.neg <= diff[RW-1];
      sign_r.pos <= !diff[RW-1] && (diff != '0);
    end
  end

endmodule

`default_nettype wire

// ===== src/triangle_triangle_intersect_test.sv =====
// An accepted input transaction passes through every registered pipeline stage before its result reaches the output.
// Throughput: one triangle pair per cycle while out_ready is not held low; every stage carries its own valid bit.
// A stalled output holds every valid stage back to the nearest bubble; stages before a bubble keep advancing into it.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none

module triangle_triangle_intersect_test #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [3*COORD_BITS-1:0]   in_tri_a_v0,
  input  wire logic [3*COORD_BITS-1:0]   in_tri_a_v1,
  input  wire logic [3*COORD_BITS-1:0]   in_tri_a_v2,
  input  wire logic [3*COORD_BITS-1:0]   in_tri_b_v0,
  input  wire logic [3*COORD_BITS-1:0]   in_tri_b_v1,
  input  wire logic [3*COORD_BITS-1:0]   in_tri_b_v2,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_intersects
);
  import ttit_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int NW = 2 * C + 3;
  localparam int PW = 3 * C + 4;
  localparam int SW = 3 * C + 6;
  localparam int NS = 9;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic signed [C-1:0]  crd_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [NW-1:0] nrm_t;
  typedef logic signed [PW-1:0] trm_t;
  typedef logic signed [SW-1:0] sum_t;

  function automatic nrm_t xprod(input dif_t p, input dif_t q, input dif_t r, input dif_t s);
    return NW'(p) * NW'(q) - NW'(r) * NW'(s);
  endfunction

  function automatic logic [1:0] drop_axis(input nrm_t n0, input nrm_t n1, input nrm_t n2);
    logic [NW-1:0] x, y, z;
    x = n0[NW-1] ? NW'(-n0) : NW'(n0);
    y = n1[NW-1] ? NW'(-n1) : NW'(n1);
    z = n2[NW-1] ? NW'(-n2) : NW'(n2);
    if (x >= y && x >= z) return AXIS_X;
    if (y >= z) return AXIS_Y;
    return AXIS_Z;
  endfunction

  function automatic crd_t proj_u(input logic [1:0] ax, input crd_t x, input crd_t y,
                                  input crd_t z);
    case (ax)
      AXIS_X:  return y;
      AXIS_Y:  return z;
      default: return x;
    endcase
  endfunction

  function automatic crd_t proj_v(input logic [1:0] ax, input crd_t x, input crd_t y,
                                  input crd_t z);
    case (ax)
      AXIS_X:  return z;
      AXIS_Y:  return x;
      default: return y;
    endcase
  endfunction

  function automatic logic in_box(input crd_t au, input crd_t av, input crd_t bu,
                                  input crd_t bv, input crd_t pu, input crd_t pv);
    crd_t lu, hu, lv, hv;
    lu = (au < bu) ? au : bu;
    hu = (au > bu) ? au : bu;
    lv = (av < bv) ? av : bv;
    hv = (av > bv) ? av : bv;
    return !(pu < lu || pu > hu || pv < lv || pv > hv);
  endfunction

  function automatic logic inside3(input sgn_t x, input sgn_t y, input sgn_t z);
    return !((x.neg | y.neg | z.neg) & (x.pos | y.pos | z.pos));
  endfunction

  function automatic sgn_t dot_sign(input trm_t p0, input trm_t p1, input trm_t p2);
    sum_t sm;
    sgn_t r;
    sm = SW'(p0) + SW'(p1) + SW'(p2);
    r.neg = sm[SW-1];
    r.pos = !sm[SW-1] && (sm != '0);
    return r;
  endfunction

  // Handshake and stage enables.
  logic [NS:1] v_r;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: unpack vertices.
  crd_t in_a [3][3];
  crd_t in_b [3][3];
  crd_t va1_r [3][3];
  crd_t vb1_r [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_a[0][k] = in_tri_a_v0[k*C +: C];
      in_a[1][k] = in_tri_a_v1[k*C +: C];
      in_a[2][k] = in_tri_a_v2[k*C +: C];
      in_b[0][k] = in_tri_b_v0[k*C +: C];
      in_b[1][k] = in_tri_b_v1[k*C +: C];
      in_b[2][k] = in_tri_b_v2[k*C +: C];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      va1_r <= in_a;
      vb1_r <= in_b;
    end
  end

  // Stage 2: edge vectors and offsets to the other triangle.
  crd_t va2_r [3][3];
  crd_t vb2_r [3][3];
  dif_t ea2_r [2][3];
  dif_t eb2_r [2][3];
  dif_t da2_r [3][3];
  dif_t db2_r [3][3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      va2_r <= va1_r;
      vb2_r <= vb1_r;
      for (int k = 0; k < 3; k++) begin
        ea2_r[0][k] <= DW'(va1_r[1][k]) - DW'(va1_r[0][k]);
        ea2_r[1][k] <= DW'(va1_r[2][k]) - DW'(va1_r[0][k]);
        eb2_r[0][k] <= DW'(vb1_r[1][k]) - DW'(vb1_r[0][k]);
        eb2_r[1][k] <= DW'(vb1_r[2][k]) - DW'(vb1_r[0][k]);
        for (int i = 0; i < 3; i++) begin
          da2_r[i][k] <= DW'(va1_r[0][k]) - DW'(vb1_r[i][k]);
          db2_r[i][k] <= DW'(vb1_r[0][k]) - DW'(va1_r[i][k]);
        end
      end
    end
  end

  // Stage 3: plane normals.
  crd_t va3_r [3][3];
  crd_t vb3_r [3][3];
  nrm_t na3_r [3];
  nrm_t nb3_r [3];
  dif_t da3_r [3][3];
  dif_t db3_r [3][3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      va3_r <= va2_r;
      vb3_r <= vb2_r;
      da3_r <= da2_r;
      db3_r <= db2_r;
      na3_r[0] <= xprod(ea2_r[0][1], ea2_r[1][2], ea2_r[0][2], ea2_r[1][1]);
      na3_r[1] <= xprod(ea2_r[0][2], ea2_r[1][0], ea2_r[0][0], ea2_r[1][2]);
      na3_r[2] <= xprod(ea2_r[0][0], ea2_r[1][1], ea2_r[0][1], ea2_r[1][0]);
      nb3_r[0] <= xprod(eb2_r[0][1], eb2_r[1][2], eb2_r[0][2], eb2_r[1][1]);
      nb3_r[1] <= xprod(eb2_r[0][2], eb2_r[1][0], eb2_r[0][0], eb2_r[1][2]);
      nb3_r[2] <= xprod(eb2_r[0][0], eb2_r[1][1], eb2_r[0][1], eb2_r[1][0]);
    end
  end

  // Stage 4: plane-side products and projections.
  logic [1:0] axa, axb;
  crd_t       va4_r [3][3];
  crd_t       vb4_r [3][3];
  trm_t       pa4_r [3][3];
  trm_t       pb4_r [3][3];
  logic       za4_r, zb4_r;
  crd_t       ua4_r [6];
  crd_t       wa4_r [6];
  crd_t       ub4_r [6];
  crd_t       wb4_r [6];

  assign axa = drop_axis(na3_r[0], na3_r[1], na3_r[2]);
  assign axb = drop_axis(nb3_r[0], nb3_r[1], nb3_r[2]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      va4_r <= va3_r;
      vb4_r <= vb3_r;
      za4_r <= (na3_r[0] == '0) && (na3_r[1] == '0) && (na3_r[2] == '0);
      zb4_r <= (nb3_r[0] == '0) && (nb3_r[1] == '0) && (nb3_r[2] == '0);
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pa4_r[i][k] <= PW'(da3_r[i][k]) * PW'(na3_r[k]);
          pb4_r[i][k] <= PW'(db3_r[i][k]) * PW'(nb3_r[k]);
        end
        ua4_r[i]   <= proj_u(axa, va3_r[i][0], va3_r[i][1], va3_r[i][2]);
        wa4_r[i]   <= proj_v(axa, va3_r[i][0], va3_r[i][1], va3_r[i][2]);
        ua4_r[i+3] <= proj_u(axa, vb3_r[i][0], vb3_r[i][1], vb3_r[i][2]);
        wa4_r[i+3] <= proj_v(axa, vb3_r[i][0], vb3_r[i][1], vb3_r[i][2]);
        ub4_r[i]   <= proj_u(axb, va3_r[i][0], va3_r[i][1], va3_r[i][2]);
        wb4_r[i]   <= proj_v(axb, va3_r[i][0], va3_r[i][1], va3_r[i][2]);
        ub4_r[i+3] <= proj_u(axb, vb3_r[i][0], vb3_r[i][1], vb3_r[i][2]);
        wb4_r[i+3] <= proj_v(axb, vb3_r[i][0], vb3_r[i][1], vb3_r[i][2]);
      end
    end
  end

  // Stages 5 and 6: projected orientations, one unit per edge/vertex pair and projection.
  sgn_t oba6 [3][3];
  sgn_t oab6 [3][3];
  sgn_t qba6 [3][3];

  for (genvar j = 0; j < 3; j++) begin : g_edge
    localparam int J1 = (j == 2) ? 0 : j + 1;
    for (genvar i = 0; i < 3; i++) begin : g_vert
      ttit_orient2 #(.COORD_BITS(C)) u_oba (
        .clk(clk), .en_prod(en[5]), .en_sign(en[6]),
        .a_u(ua4_r[3+j]), .a_v(wa4_r[3+j]), .b_u(ua4_r[3+J1]), .b_v(wa4_r[3+J1]),
        .p_u(ua4_r[i]), .p_v(wa4_r[i]), .sign_r(oba6[j][i])
      );
      ttit_orient2 #(.COORD_BITS(C)) u_oab (
        .clk(clk), .en_prod(en[5]), .en_sign(en[6]),
        .a_u(ua4_r[j]), .a_v(wa4_r[j]), .b_u(ua4_r[J1]), .b_v(wa4_r[J1]),
        .p_u(ua4_r[3+i]), .p_v(wa4_r[3+i]), .sign_r(oab6[j][i])
      );
      ttit_orient2 #(.COORD_BITS(C)) u_qba (
        .clk(clk), .en_prod(en[5]), .en_sign(en[6]),
        .a_u(ub4_r[3+j]), .a_v(wb4_r[3+j]), .b_u(ub4_r[3+J1]), .b_v(wb4_r[3+J1]),
        .p_u(ub4_r[i]), .p_v(wb4_r[i]), .sign_r(qba6[j][i])
      );
    end
  end

  // Stage 5: plane-side signs and bounding box checks.
  crd_t va5_r [3][3];
  crd_t vb5_r [3][3];
  sgn_t s5_r [3];
  sgn_t t5_r [3];
  logic za5_r, zb5_r;
  logic bxba5_r [3][3];
  logic bxab5_r [3][3];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      va5_r <= va4_r;
      vb5_r <= vb4_r;
      za5_r <= za4_r;
      zb5_r <= zb4_r;
      for (int i = 0; i < 3; i++) begin
        s5_r[i] <= dot_sign(pa4_r[i][0], pa4_r[i][1], pa4_r[i][2]);
        t5_r[i] <= dot_sign(pb4_r[i][0], pb4_r[i][1], pb4_r[i][2]);
      end
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          bxba5_r[j][i] <= in_box(ua4_r[3+j], wa4_r[3+j],
                                  ua4_r[(j == 2) ? 3 : 4 + j], wa4_r[(j == 2) ? 3 : 4 + j],
                                  ua4_r[i], wa4_r[i]);
          bxab5_r[j][i] <= in_box(ua4_r[j], wa4_r[j],
                                  ua4_r[(j == 2) ? 0 : j + 1], wa4_r[(j == 2) ? 0 : j + 1],
                                  ua4_r[3+i], wa4_r[3+i]);
        end
      end
    end
  end

  // Stage 6: vertex permutation for the general case.
  crd_t pa1 [3];
  crd_t pb1 [3];
  crd_t pc1 [3];
  crd_t pa2 [3];
  crd_t pb2 [3];
  crd_t pc2 [3];

  always_comb begin
    crd_t tmp [3];
    sgn_t sw [3];
    logic iu_neg, iv_neg;
    pa1 = va5_r[0];
    pb1 = va5_r[1];
    pc1 = va5_r[2];
    pa2 = vb5_r[0];
    pb2 = vb5_r[1];
    pc2 = vb5_r[2];
    tmp = vb5_r[0];
    sw  = s5_r;
    iu_neg = 1'b0;
    iv_neg = 1'b0;
    if (!sg_prod_neg(t5_r[1], t5_r[2]) && sg_nz(t5_r[0])) begin
      iu_neg = t5_r[0].neg;
    end else if (!sg_prod_neg(t5_r[0], t5_r[2]) && sg_nz(t5_r[1])) begin
      pa1 = va5_r[1];
      pb1 = va5_r[2];
      pc1 = va5_r[0];
      iu_neg = t5_r[1].neg;
    end else if (!sg_prod_neg(t5_r[0], t5_r[1]) && sg_nz(t5_r[2])) begin
      pa1 = va5_r[2];
      pb1 = va5_r[0];
      pc1 = va5_r[1];
      iu_neg = t5_r[2].neg;
    end
    if (iu_neg) begin
      pb2 = vb5_r[2];
      pc2 = vb5_r[1];
      sw[1] = s5_r[2];
      sw[2] = s5_r[1];
    end
    if (!sg_prod_neg(sw[1], sw[2]) && sg_nz(sw[0])) begin
      iv_neg = sw[0].neg;
    end else if (!sg_prod_neg(sw[0], sw[2]) && sg_nz(sw[1])) begin
      tmp = pa2;
      pa2 = pb2;
      pb2 = pc2;
      pc2 = tmp;
      iv_neg = sw[1].neg;
    end else if (!sg_prod_neg(sw[0], sw[1]) && sg_nz(sw[2])) begin
      tmp = pa2;
      pa2 = pc2;
      pc2 = pb2;
      pb2 = tmp;
      iv_neg = sw[2].neg;
    end
    if (iv_neg) begin
      tmp = pb1;
      pb1 = pc1;
      pc1 = tmp;
    end
  end

  sgn_t s6_r [3];
  sgn_t t6_r [3];
  logic za6_r, zb6_r;
  logic bxba6_r [3][3];
  logic bxab6_r [3][3];
  dif_t fx6_r [2][3];
  dif_t fy6_r [2][3];
  dif_t fz6_r [2][3];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_r    <= s5_r;
      t6_r    <= t5_r;
      za6_r   <= za5_r;
      zb6_r   <= zb5_r;
      bxba6_r <= bxba5_r;
      bxab6_r <= bxab5_r;
      for (int k = 0; k < 3; k++) begin
        fx6_r[0][k] <= DW'(pa1[k]) - DW'(pb2[k]);
        fy6_r[0][k] <= DW'(pb1[k]) - DW'(pb2[k]);
        fz6_r[0][k] <= DW'(pa2[k]) - DW'(pb2[k]);
        fx6_r[1][k] <= DW'(pa1[k]) - DW'(pa2[k]);
        fy6_r[1][k] <= DW'(pc1[k]) - DW'(pa2[k]);
        fz6_r[1][k] <= DW'(pc2[k]) - DW'(pa2[k]);
      end
    end
  end

  // Stage 7: early decisions and cross products for the final orientations.
  logic seg_hit [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_sa
    localparam int I1 = (i == 2) ? 0 : i + 1;
    for (genvar j = 0; j < 3; j++) begin : g_sb
      localparam int J1 = (j == 2) ? 0 : j + 1;
      assign seg_hit[i][j] =
        (sg_prod_neg(oba6[j][i], oba6[j][I1]) && sg_prod_neg(oab6[i][j], oab6[i][J1])) ||
        (!sg_nz(oba6[j][i])  && bxba6_r[j][i])  ||
        (!sg_nz(oba6[j][I1]) && bxba6_r[j][I1]) ||
        (!sg_nz(oab6[i][j])  && bxab6_r[i][j])  ||
        (!sg_nz(oab6[i][J1]) && bxab6_r[i][J1]);
    end
  end

  logic early_c, eval_c;

  always_comb begin
    logic copl, any_seg, lone_found;
    logic ins_a [3];
    logic ins_b [3];
    any_seg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        any_seg = any_seg | seg_hit[i][j];
      end
      ins_a[i] = inside3(oab6[0][i], oab6[1][i], oab6[2][i]);
      ins_b[i] = inside3(qba6[0][i], qba6[1][i], qba6[2][i]);
    end
    copl = any_seg || inside3(oba6[0][0], oba6[1][0], oba6[2][0]) || ins_a[0];
    early_c    = 1'b1;
    eval_c     = 1'b0;
    lone_found = 1'b0;
    if (za6_r || zb6_r) begin
      eval_c = 1'b0;
    end else if (s6_r[0] == s6_r[1] && s6_r[1] == s6_r[2]) begin
      eval_c = !sg_nz(s6_r[0]) && copl;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (!lone_found && !sg_nz(s6_r[i]) &&
            sg_prod_pos(s6_r[(i == 2) ? 0 : i + 1], s6_r[(i == 0) ? 2 : i - 1])) begin
          lone_found = 1'b1;
          eval_c     = ins_a[i];
        end
      end
      if (!lone_found) begin
        if (t6_r[0] == t6_r[1] && t6_r[1] == t6_r[2] && sg_nz(t6_r[0])) begin
          eval_c = 1'b0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (!lone_found && !sg_nz(t6_r[i]) &&
                sg_prod_pos(t6_r[(i == 2) ? 0 : i + 1], t6_r[(i == 0) ? 2 : i - 1])) begin
              lone_found = 1'b1;
              eval_c     = ins_b[i];
            end
          end
          early_c = lone_found;
        end
      end
    end
  end

  logic early7_r, eval7_r;
  dif_t fx7_r [2][3];
  nrm_t fn7_r [2][3];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      early7_r <= early_c;
      eval7_r  <= eval_c;
      fx7_r    <= fx6_r;
      for (int q = 0; q < 2; q++) begin
        fn7_r[q][0] <= xprod(fy6_r[q][1], fz6_r[q][2], fy6_r[q][2], fz6_r[q][1]);
        fn7_r[q][1] <= xprod(fy6_r[q][2], fz6_r[q][0], fy6_r[q][0], fz6_r[q][2]);
        fn7_r[q][2] <= xprod(fy6_r[q][0], fz6_r[q][1], fy6_r[q][1], fz6_r[q][0]);
      end
    end
  end

  // Stage 8: final orientation products.
  logic early8_r, eval8_r;
  trm_t fp8_r [2][3];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      early8_r <= early7_r;
      eval8_r  <= eval7_r;
      for (int q = 0; q < 2; q++) begin
        for (int k = 0; k < 3; k++) begin
          fp8_r[q][k] <= PW'(fx7_r[q][k]) * PW'(fn7_r[q][k]);
        end
      end
    end
  end

  // Stage 9: result register.
  sgn_t g0, g1;
  logic res9_r;

  assign g0 = dot_sign(fp8_r[0][0], fp8_r[0][1], fp8_r[0][2]);
  assign g1 = dot_sign(fp8_r[1][0], fp8_r[1][1], fp8_r[1][2]);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      res9_r <= early8_r ? eval8_r : (!g0.pos && !g1.pos);
    end
  end

  assign out_intersects = res9_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("input blocked while the pipeline has room");

  a_degenerate_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] && en[7] && (za6_r || zb6_r) |=> early7_r && !eval7_r)
    else $error("degenerate triangle not rejected");

  a_one_side_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] && en[7] && !za6_r && !zb6_r && s6_r[0].pos && s6_r[1].pos && s6_r[2].pos
    |=> early7_r && !eval7_r)
    else $error("triangle strictly on one side not rejected");

endmodule

`default_nettype wire
